### rtl/core/srpm_pkg.sv
package srpm_pkg;

    // Stream payload widths (fields packed from bit 0 up, padded to bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_PHASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWITCH_ENABLE   = 1'b1;

    localparam int BYTE_W = 8;

    // Mode codes on the input stream
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_WRITE,
        REQ_READ
    } req_kind_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] wval;
        logic              sdout;
    } item_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

endpackage

### rtl/core/srpm_front.sv
module srpm_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srpm_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [srpm_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output srpm_pkg::item_t                     item
);
    import srpm_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Sort the tick: mode 3 is a plain tick like mode 0
    always_comb
    begin
        unique case (s_tuser)
            MODE_WRITE: item.kind = REQ_WRITE;
            MODE_READ:  item.kind = REQ_READ;
            default:    item.kind = REQ_NONE;
        endcase
        item.addr  = s_tdata[7:0];
        item.wval  = s_tdata[15:8];
        item.sdout = s_tdata[16];
    end

endmodule

### rtl/core/srpm_queue.sv
module srpm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  srpm_pkg::q_ctrl_t ctrl_in,
    output logic              full,
    input  srpm_pkg::item_t   din,
    input  logic              pop,
    output logic              valid,
    output srpm_pkg::item_t   dout
);
    import srpm_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = ctrl_in.push && !ctrl_in.full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/core/srpm_back.sv
module srpm_back #(
    parameter int FIELD_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_valid,
    input  srpm_pkg::item_t                     item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srpm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import srpm_pkg::*;

    localparam int FRAME_BITS = 2 * FIELD_BITS;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);

    // configuration
    logic [7:0] tpp_reg;
    logic       sw_en_reg;

    // sequencer state
    phase_t                  phase_reg, phase_next;
    logic                    main_reg, main_next;
    logic                    read_reg, read_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0]   oshift_reg, oshift_next;
    logic [FIELD_BITS-1:0]   ishift_reg, ishift_next;
    logic [7:0]              timer_reg, timer_next;
    logic [FRAME_BITS-1:0]   saved_reg, saved_next;
    logic                    sen_reg, sen_next;
    logic                    sclk_reg, sclk_next;
    logic                    sdata_reg, sdata_next;

    // output register
    logic                    ovalid_reg, ovalid_next;
    logic [OUT_TDATA_W-1:0]  odata_reg, odata_next;

    logic                    request;
    logic                    new_read;
    logic [FIELD_BITS-1:0]   addr_f, data_f;
    logic [FRAME_BITS-1:0]   new_saved, switch_bits, first_bits;
    logic [FRAME_BITS-1:0]   oshift_sh;
    logic [CNT_W-1:0]        cnt_inc;
    logic [7:0]              plm1;
    logic                    sent_old, sent_new, frame_end;
    logic                    done, rej;
    logic [BYTE_W-1:0]       rval;

    assign q_pop    = q_valid && (!ovalid_reg || m_tready);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    assign request     = (item.kind != REQ_NONE);
    assign new_read    = (item.kind == REQ_READ);
    assign addr_f      = FIELD_BITS'({8'b0, item.addr});
    assign data_f      = FIELD_BITS'({8'b0, item.wval});
    assign new_saved   = new_read ? {addr_f, {FIELD_BITS{1'b0}}} : {addr_f, data_f};
    assign switch_bits = FRAME_BITS'(new_read);
    assign first_bits  = sw_en_reg ? switch_bits : new_saved;
    assign plm1        = (tpp_reg == 8'd0) ? 8'd0 : tpp_reg - 8'd1;
    assign oshift_sh   = {oshift_reg[FRAME_BITS-2:0], 1'b0};
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign frame_end   = (cnt_inc >= CNT_W'(FRAME_BITS));
    // read frame: the data half shifts bits in instead of out
    assign sent_old    = !(read_reg && main_reg && (cnt_reg >= CNT_W'(FIELD_BITS)));
    assign sent_new    = !(read_reg && main_reg && (cnt_inc >= CNT_W'(FIELD_BITS)));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (request)
                    begin
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (timer_reg == 8'd0)
                    begin
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    if (timer_reg == 8'd0)
                    begin
                        phase_next = frame_end ? PH_GAP : PH_HIGH;
                    end
                end
                PH_GAP:
                begin
                    if (timer_reg == 8'd0)
                    begin
                        phase_next = main_reg ? PH_IDLE : PH_HIGH;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        main_next   = main_reg;
        read_next   = read_reg;
        cnt_next    = cnt_reg;
        oshift_next = oshift_reg;
        ishift_next = ishift_reg;
        timer_next  = timer_reg;
        saved_next  = saved_reg;
        sen_next    = sen_reg;
        sclk_next   = sclk_reg;
        sdata_next  = sdata_reg;
        done        = 1'b0;
        rej         = 1'b0;
        rval        = '0;

        if (q_pop)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (request)
                begin
                    read_next   = new_read;
                    ishift_next = '0;
                    saved_next  = new_saved;
                    oshift_next = first_bits;
                    cnt_next    = '0;
                    main_next   = !sw_en_reg;
                    timer_next  = plm1;
                    sen_next    = 1'b0;
                    sclk_next   = 1'b1;
                    sdata_next  = first_bits[FRAME_BITS-1];
                end
            end
            else
            begin
                rej = request;
                if (timer_reg != 8'd0)
                begin
                    timer_next = timer_reg - 8'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HIGH:
                        begin
                            timer_next = plm1;
                            sclk_next  = 1'b0;
                        end
                        PH_LOW:
                        begin
                            if (!sent_old)
                            begin
                                ishift_next = {ishift_reg[FIELD_BITS-2:0], item.sdout};
                            end
                            oshift_next = oshift_sh;
                            cnt_next    = cnt_inc;
                            timer_next  = plm1;
                            if (frame_end)
                            begin
                                sen_next   = 1'b1;
                                sclk_next  = 1'b1;
                                sdata_next = 1'b0;
                            end
                            else
                            begin
                                sen_next  = 1'b0;
                                sclk_next = 1'b1;
                                if (sent_new)
                                begin
                                    sdata_next = oshift_sh[FRAME_BITS-1];
                                end
                            end
                        end
                        default:
                        begin
                            // gap phase over
                            if (!main_reg)
                            begin
                                oshift_next = saved_reg;
                                cnt_next    = '0;
                                main_next   = 1'b1;
                                timer_next  = plm1;
                                sen_next    = 1'b0;
                                sclk_next   = 1'b1;
                                sdata_next  = saved_reg[FRAME_BITS-1];
                            end
                            else
                            begin
                                timer_next = 8'd0;
                                done       = 1'b1;
                                if (read_reg)
                                begin
                                    rval = BYTE_W'(ishift_reg);
                                end
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (q_pop)
        begin
            ovalid_next = 1'b1;
            odata_next  = OUT_TDATA_W'({rej, rval, done, (phase_next != PH_IDLE),
                                        sdata_next, sclk_next, sen_next});
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_reg    <= 8'd1;
            sw_en_reg  <= 1'b1;
            phase_reg  <= PH_IDLE;
            main_reg   <= 1'b0;
            read_reg   <= 1'b0;
            cnt_reg    <= '0;
            oshift_reg <= '0;
            ishift_reg <= '0;
            timer_reg  <= 8'd0;
            saved_reg  <= '0;
            sen_reg    <= 1'b1;
            sclk_reg   <= 1'b1;
            sdata_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_TICKS_PER_PHASE))
            begin
                tpp_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_SWITCH_ENABLE))
            begin
                sw_en_reg <= cfg_data[0];
            end
            phase_reg  <= phase_next;
            main_reg   <= main_next;
            read_reg   <= read_next;
            cnt_reg    <= cnt_next;
            oshift_reg <= oshift_next;
            ishift_reg <= ishift_next;
            timer_reg  <= timer_next;
            saved_reg  <= saved_next;
            sen_reg    <= sen_next;
            sclk_reg   <= sclk_next;
            sdata_reg  <= sdata_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

endmodule

### rtl/core/serial_register_port_master_top.sv
// Channel   Direction  Transaction carries
// --------  ---------  ---------------------------------------------------
// s_*       in         one time tick: mode plus address, write byte, SDOUT
// m_*       out        pin levels after the tick, busy/done, read byte, reject
// cfg_*     in         write of ticks_per_phase (0) or switch_frame_enable (1)
//
// One transaction per clock while the output is not stalled; a transaction
// passes the two-entry queue, then the sequencer into the output register.
// The sequencer takes one step per tick; its phase timer and bit counter set
// the pin timing, not the clock. Reset leaves SEN and SCLK high, SDATA low.
// A stalled output holds its register; the queue absorbs input meanwhile and
// drops s_tready only when both entries are taken.
module serial_register_port_master_top #(
    parameter int FIELD_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] register_address, [15:8] write_value, [16] sdout_pin
    input  logic [srpm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] mode
    input  logic [srpm_pkg::IN_TUSER_W-1:0]     s_tuser,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] sen_pin, [1] sclk_pin, [2] sdata_pin, [3] busy_res, [4] done_res,
    // [12:5] read_value, [13] rejected
    output logic [srpm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration
    input  logic                                cfg_we,
    input  logic [srpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import srpm_pkg::*;

    item_t   front_item;
    item_t   q_item;
    q_ctrl_t q_ctrl;
    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.full = q_full;

    // Front: decode the tick kind, push into the queue
    srpm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .item     (front_item)
    );

    // Two-entry queue lets front and sequencer stall independently
    srpm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (q_ctrl),
        .full    (q_full),
        .din     (front_item),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_item)
    );

    // Back: frame sequencer, pin shadow and output register
    srpm_back #(
        .FIELD_BITS (FIELD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .item      (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### tb/serial_register_port_master_top_test.sv
`timescale 1ns / 1ps

module serial_register_port_master_top_test;

    import srpm_pkg::*;

    localparam int FIELD_W     = 8;
    localparam int FRAME_W     = 2 * FIELD_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PROBE_ROWS  = 12;
    localparam int CFG_PHASES  = 6;

    // modes with no entry in the package
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One output transaction, laid out as on m_tdata (sen_pin in bit 0).
    typedef struct packed {
        logic       rejected;
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
        logic       sdata_pin;
        logic       sclk_pin;
        logic       sen_pin;
    } pin_report_t;

    localparam int REPORT_W = $bits(pin_report_t);

    // Hand-computed reports for the directed rows that are easy to read off.
    localparam pin_report_t UNTYPED     = '0;
    localparam pin_report_t IDLE_PINS   = 14'h0003; // SEN, SCLK high, not busy
    localparam pin_report_t FRAME_OPEN  = 14'h000A; // SEN low, SCLK high, busy
    localparam pin_report_t BUSY_REJECT = 14'h2008; // SCLK falls, request dropped
    localparam pin_report_t DONE_REJECT = 14'h2013; // completion with a dropped request

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  addr;
        logic [7:0]  wval;
        logic        sdout;
        logic        at_done;  // tick up to the completing step before this row
        logic        settle;   // tick until the sequencer is idle after this row
        logic        typed;    // compare against want instead of the predictor
        pin_report_t want;
    } probe_row_t;

    // Directed rows, run at reset settings (one tick per phase, switch frame on).
    //                     mode        addr   wval   sdo   done  setl  typed want
    probe_row_t probe_rows [PROBE_ROWS] = '{
        {MODE_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, IDLE_PINS},   // idle after reset
        {MODE_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, IDLE_PINS},   // unused mode = tick
        {MODE_WRITE, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, FRAME_OPEN},  // switch frame opens
        {MODE_READ,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, BUSY_REJECT}, // request while busy
        {MODE_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, UNTYPED},
        {MODE_READ,  8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, UNTYPED},     // SDATA holds addr LSB
        {MODE_READ,  8'h80, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, UNTYPED},     // reads all zeros
        {MODE_WRITE, 8'hA5, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
        {MODE_WRITE, 8'h3C, 8'hC3, 1'b0, 1'b1, 1'b0, 1'b1, DONE_REJECT}, // request on done tick
        {MODE_READ,  8'h01, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
        {MODE_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, UNTYPED},     // done tick with byte
        {MODE_READ,  8'h7F, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0, UNTYPED}      // start right after done
    };

    // Settings walked by the random part; the 5-tick entry is redrawn at run time.
    // The directed rows and the idle waits between settings add several hundred
    // more ticks on top of these counts.
    int phase_ticks  [CFG_PHASES] = '{0, 1, 2, 3, 5, 255};
    int phase_switch [CFG_PHASES] = '{1, 0, 0, 1, 1, 0};
    int phase_items  [CFG_PHASES] = '{130, 130, 80, 50, 30, 20};

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata   = '0;
    logic [IN_TUSER_W-1:0]    s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    int cycle_count = 0;
    int error_count = 0;
    int burst_left  = 0;

    // Receiver stall pattern: style changes every span of cycles.
    int rcv_style = 0;
    int rcv_span  = 0;

    // Expected output transactions, oldest first
    pin_report_t pin_forecast [$];

    // Predictor copy of the configuration and sequencer state
    logic [7:0]  ticks_cfg;
    logic        switch_cfg;
    phase_t      seq_phase;
    logic        main_frame;
    logic        reading;
    logic [4:0]  bits_done;
    logic [15:0] tx_shift;
    logic [7:0]  rx_shift;
    logic [7:0]  phase_cnt;
    logic [15:0] held_frame;
    logic        pin_sen;
    logic        pin_sclk;
    logic        pin_sdata;

    serial_register_port_master_top #(
        .FIELD_BITS (FIELD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] addr, [15:8] write byte, [16] sdout
        .s_tuser   (s_tuser),   // [1:0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] sen .. [4] done, [12:5] read byte, [13] rejected
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero ticks per phase behaves like one.
    function automatic logic [7:0] phase_reload();
        return (ticks_cfg == 8'd0) ? 8'd0 : ticks_cfg - 8'd1;
    endfunction

    // False only while the read byte is being shifted in: SDATA then holds
    // the last address bit.
    function automatic logic drives_sdata();
        return !(reading && main_frame && bits_done >= FIELD_W);
    endfunction

    function automatic void raise_sclk();
        seq_phase = PH_HIGH;
        phase_cnt = phase_reload();
        pin_sen   = 1'b0;
        pin_sclk  = 1'b1;
        if (drives_sdata())
            pin_sdata = tx_shift[FRAME_W-1];
    endfunction

    function automatic void open_frame(logic [15:0] bits, logic is_main);
        tx_shift   = bits;
        bits_done  = '0;
        main_frame = is_main;
        raise_sclk();
    endfunction

    // One tick of the sequencer; returns the output transaction it causes.
    function automatic pin_report_t advance_sequencer(logic [1:0] mode, logic [7:0] addr,
                                                      logic [7:0] wval, logic sdout);
        pin_report_t rpt;
        logic        request;
        rpt     = '0;
        request = (mode == MODE_WRITE) || (mode == MODE_READ);
        if (seq_phase == PH_IDLE)
        begin
            if (request)
            begin
                reading    = (mode == MODE_READ);
                rx_shift   = '0;
                held_frame = reading ? {addr, 8'h00} : {addr, wval};
                // switch frame: register 0, value 1 for read, 0 for write
                if (switch_cfg)
                    open_frame({15'd0, reading}, 1'b0);
                else
                    open_frame(held_frame, 1'b1);
            end
        end
        else
        begin
            rpt.rejected = request;
            if (phase_cnt != 8'd0)
            begin
                phase_cnt = phase_cnt - 8'd1;
            end
            else
            begin
                case (seq_phase)
                    PH_HIGH:
                    begin
                        seq_phase = PH_LOW;
                        phase_cnt = phase_reload();
                        pin_sclk  = 1'b0;
                    end
                    PH_LOW:
                    begin
                        // read bits are taken at the end of the low phase
                        if (!drives_sdata())
                            rx_shift = {rx_shift[6:0], sdout};
                        tx_shift  = tx_shift << 1;
                        bits_done = bits_done + 5'd1;
                        if (bits_done >= FRAME_W)
                        begin
                            seq_phase = PH_GAP;
                            phase_cnt = phase_reload();
                            pin_sen   = 1'b1;
                            pin_sclk  = 1'b1;
                            pin_sdata = 1'b0;
                        end
                        else
                        begin
                            raise_sclk();
                        end
                    end
                    default:
                    begin
                        if (!main_frame)
                        begin
                            open_frame(held_frame, 1'b1);
                        end
                        else
                        begin
                            seq_phase    = PH_IDLE;
                            phase_cnt    = '0;
                            rpt.done_res = 1'b1;
                            if (reading)
                                rpt.read_value = rx_shift;
                        end
                    end
                endcase
            end
        end
        rpt.sen_pin   = pin_sen;
        rpt.sclk_pin  = pin_sclk;
        rpt.sdata_pin = pin_sdata;
        rpt.busy_res  = (seq_phase != PH_IDLE);
        return rpt;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one tick on the input stream, bursts broken by random gaps.
    // The forecast is pushed when the transaction is accepted.
    task automatic push_tick(input logic [1:0] mode, input logic [7:0] addr,
                             input logic [7:0] wval, input logic sdout,
                             input logic typed, input pin_report_t want);
        pin_report_t predicted;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, sdout, wval, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_sequencer(mode, addr, wval, sdout);
        pin_forecast.push_back(typed ? want : predicted);
    endtask

    // Block is idle when this is called; the write lands on the next edge.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_TICKS_PER_PHASE)
            ticks_cfg = value;
        else
            switch_cfg = value[0];
        @(posedge clk);
    endtask

    // Sender idle until every expected result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(posedge clk);
    endtask

    // Plain ticks until the sequencer is idle, then every result drained.
    task automatic quiesce(input logic sdout);
        while (seq_phase != PH_IDLE)
            push_tick(MODE_TICK, 8'($urandom), 8'($urandom), sdout, 1'b0, UNTYPED);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls: always ready, random, or a sparse fixed pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rcv_span == 0)
        begin
            rcv_style <= $urandom_range(0, 2);
            rcv_span  <= $urandom_range(20, 200);
        end
        else
        begin
            rcv_span <= rcv_span - 1;
        end
        case (rcv_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (cycle_count[2:0] == 3'd5);
        endcase
    end

    // ------------------------------------------------------------------
    // Output check: each accepted transaction against the oldest forecast
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pin_report_t got;
        pin_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = pin_report_t'(m_tdata[REPORT_W-1:0]);
            if (pin_forecast.size() == 0)
            begin
                $error("output transaction with nothing expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pin_forecast.pop_front();
                if (got.sen_pin !== want.sen_pin)
                begin
                    $error("sen_pin expected %0d got %0d", want.sen_pin, got.sen_pin);
                    error_count++;
                end
                if (got.sclk_pin !== want.sclk_pin)
                begin
                    $error("sclk_pin expected %0d got %0d", want.sclk_pin, got.sclk_pin);
                    error_count++;
                end
                if (got.sdata_pin !== want.sdata_pin)
                begin
                    $error("sdata_pin expected %0d got %0d", want.sdata_pin, got.sdata_pin);
                    error_count++;
                end
                if (got.busy_res !== want.busy_res)
                begin
                    $error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
                    error_count++;
                end
                if (got.done_res !== want.done_res)
                begin
                    $error("done_res expected %0d got %0d", want.done_res, got.done_res);
                    error_count++;
                end
                if (got.read_value !== want.read_value)
                begin
                    $error("read_value expected %h got %h", want.read_value, got.read_value);
                    error_count++;
                end
                if (got.rejected !== want.rejected)
                begin
                    $error("rejected expected %0d got %0d", want.rejected, got.rejected);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("serial_register_port_master_top_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        probe_row_t row;
        logic [1:0] mode;
        int         pick;
        int         tk;

        // predictor reset state
        ticks_cfg  = 8'd1;
        switch_cfg = 1'b1;
        seq_phase  = PH_IDLE;
        main_frame = 1'b0;
        reading    = 1'b0;
        bits_done  = '0;
        tx_shift   = '0;
        rx_shift   = '0;
        phase_cnt  = '0;
        held_frame = '0;
        pin_sen    = 1'b1;
        pin_sclk   = 1'b1;
        pin_sdata  = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows at reset settings
        for (int r = 0; r < PROBE_ROWS; r++)
        begin
            row = probe_rows[r];
            if (row.at_done)
            begin
                // stop one tick short of completion so the row lands on it
                while (!(seq_phase == PH_GAP && phase_cnt == 8'd0 && main_frame))
                    push_tick(MODE_TICK, 8'($urandom), 8'($urandom), row.sdout,
                              1'b0, UNTYPED);
            end
            push_tick(row.mode, row.addr, row.wval, row.sdout, row.typed, row.want);
            if (row.settle)
            begin
                while (seq_phase != PH_IDLE)
                    push_tick(MODE_TICK, 8'($urandom), 8'($urandom), row.sdout,
                              1'b0, UNTYPED);
            end
        end

        // Random part, one setting at a time. The sender pauses here until
        // every expected transaction is back before reprogramming.
        for (int p = 0; p < CFG_PHASES; p++)
        begin
            quiesce(1'($urandom));
            tk = (p == 4) ? $urandom_range(4, 9) : phase_ticks[p];
            write_register(CFG_TICKS_PER_PHASE, 8'(tk));
            write_register(CFG_SWITCH_ENABLE, {7'd0, 1'(phase_switch[p])});
            cfg_we <= 1'b0;
            for (int n = 0; n < phase_items[p]; n++)
            begin
                pick = $urandom_range(0, 19);
                // mostly clean request-then-ticks sequences, some noise
                if (seq_phase == PH_IDLE)
                    mode = (pick < 7)  ? MODE_WRITE :
                           (pick < 14) ? MODE_READ  :
                           (pick < 16) ? MODE_SPARE : MODE_TICK;
                else
                    mode = (pick == 0) ? MODE_WRITE :
                           (pick == 1) ? MODE_READ  :
                           (pick == 2) ? MODE_SPARE : MODE_TICK;
                push_tick(mode, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, UNTYPED);
            end
        end

        // the last setting may leave a frame open; only the results matter here
        drain();
        // more idle clocks so any stray output transaction gets flagged
        repeat (10) @(posedge clk);

        if (error_count == 0 && pin_forecast.size() == 0)
            $display("serial_register_port_master_top_test passed");
        else
            $display("serial_register_port_master_top_test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/srpm_pkg.sv
rtl/core/srpm_front.sv
rtl/core/srpm_queue.sv
rtl/core/srpm_back.sv
rtl/core/serial_register_port_master_top.sv
tb/serial_register_port_master_top_test.sv
